// File: rtl/mcfr_pkg.sv
// shared types and constants of the multi-channel frame receiver
`timescale 1ns / 1ps
package mcfr_pkg;

   localparam int CHANNEL_W  = 3;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int CSR_IDX_W  = 1;

   localparam int DEFAULT_CHANNELS    = 8;
   localparam int DEFAULT_FRAME_LIMIT = 32;

   // the frame may close only once this many bytes are counted
   localparam int MIN_END_COUNT  = 6;
   // header and length-field bytes in front of the payload
   localparam int FRAME_OVERHEAD = 4;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'h42;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'h4D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_FIRST  = 1'b0,
      CSR_HEADER_SECOND = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // per-channel framing state apart from the byte count
   typedef struct packed {
      logic              in_frame;
      logic [BYTE_W-1:0] last_byte;
      logic [WORD_W-1:0] length_field;
      logic [WORD_W-1:0] running_sum;
      logic [WORD_W-1:0] trailer_bytes;
   } chan_state_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel_out;
      status_type           status;
      logic [WORD_W-1:0]    payload_length;
      logic [WORD_W-1:0]    computed_sum;
      logic [WORD_W-1:0]    received_sum;
   } result_type;

endpackage

// File: rtl/mcfr_req_if.sv
// byte channel into the receiver
`timescale 1ns / 1ps
interface mcfr_req_if;
   import mcfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel;
   logic [BYTE_W-1:0]    rx_byte;

   modport source (output valid, output channel, output rx_byte, input ready);
   modport sink (input valid, input channel, input rx_byte, output ready);
endinterface

// File: rtl/mcfr_rsp_if.sv
// frame report channel out of the receiver
`timescale 1ns / 1ps
interface mcfr_rsp_if;
   import mcfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel_out;
   logic [1:0]           status;
   logic [WORD_W-1:0]    payload_length;
   logic [WORD_W-1:0]    computed_sum;
   logic [WORD_W-1:0]    received_sum;

   modport source (output valid, output channel_out, output status, output payload_length,
                   output computed_sum, output received_sum, input ready);
   modport sink (input valid, input channel_out, input status, input payload_length,
                 input computed_sum, input received_sum, output ready);
endinterface

// File: rtl/mcfr_state_mem.sv
// per-channel state memory with registered read and reset-cleared valid bits
`timescale 1ns / 1ps
module mcfr_state_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int DATA_W = 62
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as the all-zero reset state
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;
endmodule

// File: rtl/mcfr_frame_update.sv
// next framing state of one channel and the frame report it may cause
`timescale 1ns / 1ps
module mcfr_frame_update #(
   parameter int FRAME_LIMIT = 32,
   parameter int CNT_W       = 5
) (
   input  mcfr_pkg::chan_state_type    cur_state,
   input  logic [CNT_W-1:0]            cur_count,
   input  logic [mcfr_pkg::BYTE_W-1:0] rx_byte,
   input  logic [mcfr_pkg::BYTE_W-1:0] header_first,
   input  logic [mcfr_pkg::BYTE_W-1:0] header_second,
   output mcfr_pkg::chan_state_type    nxt_state,
   output logic [CNT_W-1:0]            nxt_count,
   output logic                        emit,
   output mcfr_pkg::status_type        status,
   output logic [mcfr_pkg::WORD_W-1:0] payload_length,
   output logic [mcfr_pkg::WORD_W-1:0] computed_sum,
   output logic [mcfr_pkg::WORD_W-1:0] received_sum
);
   import mcfr_pkg::*;

   localparam int CMP_W = WORD_W + 1;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(FRAME_LIMIT - 1);

   logic [CNT_W-1:0] count_inc;
   logic [CMP_W-1:0] end_count;

   always_comb begin
      nxt_state      = cur_state;
      nxt_count      = cur_count;
      emit           = 1'b0;
      status         = STATUS_GOOD;
      payload_length = '0;
      computed_sum   = '0;
      received_sum   = '0;
      count_inc      = cur_count + CNT_W'(1);
      end_count      = '0;
      if (!cur_state.in_frame) begin
         // hunting: slide a two-byte window
         if (cur_count == '0) begin
            nxt_count = CNT_W'(1);
         end else begin
            if (cur_state.last_byte == header_first && rx_byte == header_second) begin
               nxt_state.in_frame      = 1'b1;
               nxt_state.running_sum   = '0;
               nxt_state.trailer_bytes = {header_first, header_second};
               nxt_state.length_field  = '0;
            end
            nxt_count = CNT_W'(2);
         end
         nxt_state.last_byte = rx_byte;
      end else begin
         if (cur_count == CNT_W'(2)) begin
            nxt_state.length_field[WORD_W-1:BYTE_W] = rx_byte;
         end else if (cur_count == CNT_W'(3)) begin
            nxt_state.length_field[BYTE_W-1:0] = rx_byte;
         end
         // the older trailer byte leaves the window into the sum
         nxt_state.running_sum = cur_state.running_sum
                               + {{(WORD_W-BYTE_W){1'b0}}, cur_state.trailer_bytes[WORD_W-1:BYTE_W]};
         nxt_state.trailer_bytes = {cur_state.trailer_bytes[BYTE_W-1:0], rx_byte};
         end_count = {1'b0, nxt_state.length_field} + CMP_W'(FRAME_OVERHEAD);
         if (cur_count >= LAST_COUNT) begin
            emit                   = 1'b1;
            status                 = STATUS_OVERFLOW;
            payload_length         = nxt_state.length_field;
            nxt_state.in_frame     = 1'b0;
            nxt_state.length_field = '0;
            nxt_count              = '0;
         end else if (count_inc >= CNT_W'(MIN_END_COUNT) && CMP_W'(count_inc) == end_count) begin
            emit               = 1'b1;
            status             = (nxt_state.running_sum == nxt_state.trailer_bytes)
                               ? STATUS_GOOD : STATUS_BAD_SUM;
            payload_length     = nxt_state.length_field;
            computed_sum       = nxt_state.running_sum;
            received_sum       = nxt_state.trailer_bytes;
            nxt_state.in_frame = 1'b0;
            nxt_count          = '0;
         end else begin
            nxt_count = count_inc;
         end
      end
   end
endmodule

// File: rtl/mcfr_rsp_queue.sv
// output register with a skid stage for frame reports
`timescale 1ns / 1ps
module mcfr_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mcfr_pkg::result_type push_data,
   output logic                 full,
   mcfr_rsp_if.source           rsp
);
   import mcfr_pkg::*;

   result_type rsp_data_ff;
   result_type skid_data_ff;
   logic       rsp_valid_ff;
   logic       skid_valid_ff;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign full               = skid_valid_ff;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.channel_out    = rsp_data_ff.channel_out;
   assign rsp.status         = rsp_data_ff.status;
   assign rsp.payload_length = rsp_data_ff.payload_length;
   assign rsp.computed_sum   = rsp_data_ff.computed_sum;
   assign rsp.received_sum   = rsp_data_ff.received_sum;
endmodule

// File: rtl/multi_channel_frame_receiver.sv
// top level of the multi-channel frame receiver
`timescale 1ns / 1ps
// Takes one received byte per beat, tagged with its link number, and tracks
// header hunting, length and 16-bit checksum per link in a state memory with
// one entry per link. A byte is read from that memory in the cycle after it is
// taken and its updated entry is written back from the s1 stage; the last entry
// written is forwarded, so bytes of the same link may follow each other in
// consecutive cycles; the block sustains one byte per clock while not stalled.
// A byte that closes or overflows a frame yields a registered report; bytes on
// links at or above CHANNELS are dropped without one. req.ready drops only while
// output register and skid stage both hold reports. The user writes the header
// bytes through the csr port while no byte is in flight, unenforced by the block.
module multi_channel_frame_receiver #(
   parameter int CHANNELS    = mcfr_pkg::DEFAULT_CHANNELS,
   parameter int FRAME_LIMIT = mcfr_pkg::DEFAULT_FRAME_LIMIT
) (
   input  logic                           clock,
   input  logic                           reset,
   mcfr_req_if.sink                       req,
   mcfr_rsp_if.source                     rsp,
   input  logic                           csr_we,
   input  logic [mcfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcfr_pkg::BYTE_W-1:0]    csr_wdata
);
   import mcfr_pkg::*;

   localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W   = $clog2(FRAME_LIMIT);
   localparam int ENTRY_W = CNT_W + $bits(chan_state_type);
   localparam int CHK_W   = (ADDR_W > CHANNEL_W) ? ADDR_W + 1 : CHANNEL_W + 1;

   logic [BYTE_W-1:0]    header_first_ff;
   logic [BYTE_W-1:0]    header_second_ff;

   logic                 stall;
   logic                 fire;
   logic                 in_range;

   logic                 s1_valid_ff;
   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic [BYTE_W-1:0]    s1_byte_ff;

   logic [ENTRY_W-1:0]   rd_entry;
   logic [ENTRY_W-1:0]   cur_entry;
   logic [ENTRY_W-1:0]   nxt_entry;
   logic                 wb_valid_ff;
   logic [ADDR_W-1:0]    wb_addr_ff;
   logic [ENTRY_W-1:0]   wb_entry_ff;
   logic                 wr_en;
   logic [ADDR_W-1:0]    s1_addr;

   chan_state_type       cur_state;
   chan_state_type       nxt_state;
   logic [CNT_W-1:0]     cur_count;
   logic [CNT_W-1:0]     nxt_count;
   logic                 emit;
   status_type           status;
   logic [WORD_W-1:0]    payload_length;
   logic [WORD_W-1:0]    computed_sum;
   logic [WORD_W-1:0]    received_sum;
   result_type           result;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_FIRST: begin
               header_first_ff <= csr_wdata;
            end
            CSR_HEADER_SECOND: begin
               header_second_ff <= csr_wdata;
            end
            default: begin
               header_first_ff <= header_first_ff;
            end
         endcase
      end
   end

   assign req.ready = !stall;
   assign fire      = req.valid && !stall;
   assign in_range  = CHK_W'(req.channel) < CHK_W'(CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= fire && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_channel_ff <= req.channel;
         s1_byte_ff    <= req.rx_byte;
      end
   end

   mcfr_state_mem #(
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (!stall),
      .rd_addr (ADDR_W'(req.channel)),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (nxt_entry)
   );

   assign s1_addr = ADDR_W'(s1_channel_ff);
   assign wr_en   = s1_valid_ff && !stall;

   // the entry written last cycle is not yet visible in the read data
   assign cur_entry = (wb_valid_ff && wb_addr_ff == s1_addr) ? wb_entry_ff : rd_entry;
   assign cur_count = cur_entry[ENTRY_W-1 -: CNT_W];
   assign cur_state = cur_entry[$bits(chan_state_type)-1:0];
   assign nxt_entry = {nxt_count, nxt_state};

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (wr_en) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wb_addr_ff  <= s1_addr;
         wb_entry_ff <= nxt_entry;
      end
   end

   mcfr_frame_update #(
      .FRAME_LIMIT (FRAME_LIMIT),
      .CNT_W       (CNT_W)
   ) u_frame_update (
      .cur_state      (cur_state),
      .cur_count      (cur_count),
      .rx_byte        (s1_byte_ff),
      .header_first   (header_first_ff),
      .header_second  (header_second_ff),
      .nxt_state      (nxt_state),
      .nxt_count      (nxt_count),
      .emit           (emit),
      .status         (status),
      .payload_length (payload_length),
      .computed_sum   (computed_sum),
      .received_sum   (received_sum)
   );

   always_comb begin
      result.channel_out    = s1_channel_ff;
      result.status         = status;
      result.payload_length = payload_length;
      result.computed_sum   = computed_sum;
      result.received_sum   = received_sum;
   end

   mcfr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (wr_en && emit),
      .push_data (result),
      .full      (stall),
      .rsp       (rsp)
   );
endmodule

// File: sim/multi_channel_frame_receiver_test.sv
// self-checking bench for the multi-channel frame receiver: scripted rows, then random link traffic
`timescale 1ns / 1ps
module multi_channel_frame_receiver_test;
   import mcfr_pkg::*;

   localparam int LINKS         = DEFAULT_CHANNELS;
   localparam int LIMIT_BYTES   = DEFAULT_FRAME_LIMIT;
   localparam int SEQ_MAX       = 40;
   localparam int PHASES        = 5;
   localparam int PHASE_BYTES   = 280;
   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES   = 12;
   localparam int STUCK_LIMIT   = 2000;
   localparam int SCRIPT_LEN    = 19;

   typedef struct {
      logic [CHANNEL_W-1:0] ch;
      logic [BYTE_W-1:0]    b;
      bit                   typed;
      result_type           rep;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   mcfr_req_if req_ch ();
   mcfr_rsp_if rsp_ch ();

   multi_channel_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // local copy of the per-link framing state and the header setting
   chan_state_type    link_state [LINKS];
   logic [5:0]        link_count [LINKS];
   logic [BYTE_W-1:0] hdr_first;
   logic [BYTE_W-1:0] hdr_second;

   result_type pending_reports [$];
   result_type seen_want;

   // per-link byte sequences waiting to be sent
   logic [BYTE_W-1:0] backlog [LINKS][SEQ_MAX];
   int backlog_len [LINKS];
   int backlog_pos [LINKS];

   int fault_count;
   int bytes_sent;
   int burst_left;
   int stuck_cycles = 0;
   int good_seen;
   int bad_sum_seen;
   int overflow_seen;

   script_row_type script_rows [SCRIPT_LEN] = '{
      '{3'd7, 8'hFF, 1'b0, '0},
      '{3'd7, 8'h42, 1'b0, '0},
      '{3'd7, 8'h4D, 1'b0, '0},
      '{3'd7, 8'h00, 1'b0, '0},
      '{3'd7, 8'h02, 1'b0, '0},
      '{3'd0, 8'h42, 1'b0, '0},
      '{3'd7, 8'h00, 1'b0, '0},
      '{3'd0, 8'h4D, 1'b0, '0},
      // shortest frame, checksum matches
      '{3'd7, 8'h91, 1'b1, '{3'd7, STATUS_GOOD, 16'd2, 16'h0091, 16'h0091}},
      '{3'd0, 8'h00, 1'b0, '0},
      '{3'd0, 8'h03, 1'b0, '0},
      '{3'd0, 8'hFF, 1'b0, '0},
      '{3'd0, 8'hFF, 1'b0, '0},
      '{3'd0, 8'h42, 1'b1, '{3'd0, STATUS_BAD_SUM, 16'd3, 16'h0191, 16'hFF42}},
      // window starts empty after a frame: 42 then 4d is not a header here
      '{3'd0, 8'h4D, 1'b0, '0},
      '{3'd0, 8'h42, 1'b0, '0},
      '{3'd0, 8'h4D, 1'b0, '0},
      '{3'd3, 8'h00, 1'b0, '0},
      '{3'd4, 8'hFF, 1'b0, '0}
   };

   function automatic bit advance_link(input logic [CHANNEL_W-1:0] ch,
                                       input logic [BYTE_W-1:0] b, output result_type rep);
      chan_state_type s;
      logic [5:0]     n;
      bit             done;
      s    = link_state[ch];
      n    = link_count[ch];
      done = 1'b0;
      rep  = '0;
      if (!s.in_frame) begin
         if (n != 0 && s.last_byte == hdr_first && b == hdr_second) begin
            s.in_frame      = 1'b1;
            s.running_sum   = '0;
            s.trailer_bytes = {hdr_first, hdr_second};
            s.length_field  = '0;
         end
         s.last_byte = b;
         n = (n == 0) ? 6'd1 : 6'd2;
      end else begin
         if (n == 2) s.length_field[15:8] = b;
         else if (n == 3) s.length_field[7:0] = b;
         s.running_sum   = s.running_sum + {8'h00, s.trailer_bytes[15:8]};
         s.trailer_bytes = {s.trailer_bytes[7:0], b};
         if (n >= LIMIT_BYTES - 1) begin
            // overflow beats a length end on the same beat
            rep.channel_out    = ch;
            rep.status         = STATUS_OVERFLOW;
            rep.payload_length = s.length_field;
            s.in_frame     = 1'b0;
            s.length_field = '0;
            n    = '0;
            done = 1'b1;
         end else begin
            n = n + 6'd1;
            if (n >= MIN_END_COUNT && 32'(n) == 32'(s.length_field) + FRAME_OVERHEAD) begin
               rep.channel_out    = ch;
               rep.status         = (s.running_sum == s.trailer_bytes) ? STATUS_GOOD
                                                                      : STATUS_BAD_SUM;
               rep.payload_length = s.length_field;
               rep.computed_sum   = s.running_sum;
               rep.received_sum   = s.trailer_bytes;
               s.in_frame = 1'b0;
               n    = '0;
               done = 1'b1;
            end
         end
      end
      link_state[ch] = s;
      link_count[ch] = n;
      return done;
   endfunction

   // builds the next byte sequence of a link: mostly frames, some noise, some cut short
   function automatic void refill_link(input int ch);
      int          kind;
      int          n;
      int          body;
      logic [15:0] len;
      logic [15:0] frame_sum;
      logic [15:0] chk;
      bit          fits;
      kind = $urandom_range(0, 99);
      n    = 0;
      if (kind < 15) begin
         repeat ($urandom_range(1, 4)) begin
            backlog[ch][n] = ($urandom_range(0, 3) == 0) ? hdr_first : 8'($urandom);
            n++;
         end
      end else begin
         if (kind < 78) len = 16'($urandom_range(2, 27));
         else if (kind < 86) len = 16'd28;
         else if (kind < 91) len = 16'($urandom_range(0, 1));
         else len = 16'($urandom_range(29, 65535));
         fits = (len >= 2 && len <= 27);
         backlog[ch][0] = hdr_first;
         backlog[ch][1] = hdr_second;
         backlog[ch][2] = len[15:8];
         backlog[ch][3] = len[7:0];
         n    = 4;
         body = fits ? int'(len) - 2 : LIMIT_BYTES - 4;
         repeat (body) begin
            backlog[ch][n] = 8'($urandom);
            n++;
         end
         if (fits) begin
            frame_sum = '0;
            for (int k = 0; k < n; k++) frame_sum = frame_sum + {8'h00, backlog[ch][k]};
            chk = ($urandom_range(0, 3) != 0) ? frame_sum
                                              : frame_sum ^ (16'h1 << $urandom_range(0, 15));
            backlog[ch][n]     = chk[15:8];
            backlog[ch][n + 1] = chk[7:0];
            n += 2;
         end
         if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n);
      end
      backlog_len[ch] = n;
      backlog_pos[ch] = 0;
   endfunction

   task automatic send_byte(input logic [CHANNEL_W-1:0] ch, input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.channel <= ch;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      burst_left--;
      bytes_sent++;
   endtask

   // hold the byte stream until every report is in and the pipeline is empty
   task automatic settle_links();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic set_header(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
      settle_links();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEADER_FIRST;
      csr_wdata <= first;
      @(negedge clock);
      csr_index <= CSR_HEADER_SECOND;
      csr_wdata <= second;
      @(negedge clock);
      csr_we <= 1'b0;
      hdr_first  = first;
      hdr_second = second;
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endfunction

   // receiver stalls in spans of differing character
   initial begin
      int mode;
      int span;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (k % 16) >= 10;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $error("report on link %0d with nothing pending", rsp_ch.channel_out);
            fault_count++;
         end else begin
            seen_want = pending_reports.pop_front();
            check_field("channel_out", 16'(seen_want.channel_out), 16'(rsp_ch.channel_out));
            check_field("status", 16'(seen_want.status), 16'(rsp_ch.status));
            check_field("payload_length", seen_want.payload_length, rsp_ch.payload_length);
            check_field("computed_sum", seen_want.computed_sum, rsp_ch.computed_sum);
            check_field("received_sum", seen_want.received_sum, rsp_ch.received_sum);
            case (seen_want.status)
               STATUS_GOOD:    good_seen++;
               STATUS_BAD_SUM: bad_sum_seen++;
               default:        overflow_seen++;
            endcase
         end
      end
   end

   // watchdog on beats moving through either side
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
         $display("multi_channel_frame_receiver_test: errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      logic [BYTE_W-1:0]    first_set [PHASES];
      logic [BYTE_W-1:0]    second_set [PHASES];
      logic [CHANNEL_W-1:0] ch;
      logic [CHANNEL_W-1:0] focus_a;
      logic [CHANNEL_W-1:0] focus_b;
      logic [BYTE_W-1:0]    b;
      result_type           rep;
      bit                   got;
      int                   pick_mode;
      int                   pause_at;

      req_ch.valid   <= 1'b0;
      req_ch.channel <= '0;
      req_ch.rx_byte <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_HEADER_FIRST;
      csr_wdata      <= '0;
      fault_count   = 0;
      bytes_sent    = 0;
      burst_left    = 0;
      good_seen     = 0;
      bad_sum_seen  = 0;
      overflow_seen = 0;
      hdr_first  = HEADER_FIRST_RESET;
      hdr_second = HEADER_SECOND_RESET;
      for (int k = 0; k < LINKS; k++) begin
         link_state[k]  = '0;
         link_count[k]  = '0;
         backlog_len[k] = 0;
         backlog_pos[k] = 0;
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < SCRIPT_LEN; r++) begin
         send_byte(script_rows[r].ch, script_rows[r].b);
         got = advance_link(script_rows[r].ch, script_rows[r].b, rep);
         if (script_rows[r].typed) pending_reports.push_back(script_rows[r].rep);
         else if (got) pending_reports.push_back(rep);
      end

      first_set  = '{HEADER_FIRST_RESET, 8'h00, 8'hFF, 8'h55, 8'($urandom)};
      second_set = '{HEADER_SECOND_RESET, 8'hFF, 8'h00, 8'h55, 8'($urandom)};
      focus_a   = '0;
      focus_b   = '0;
      pick_mode = 0;

      for (int p = 0; p < PHASES; p++) begin
         set_header(first_set[p], second_set[p]);
         for (int k = 0; k < LINKS; k++) backlog_pos[k] = backlog_len[k];
         pause_at = $urandom_range(50, 250);
         for (int i = 0; i < PHASE_BYTES; i++) begin
            if (i == pause_at) settle_links();
            if (i % 70 == 0) begin
               pick_mode = $urandom_range(0, 2);
               focus_a   = 3'($urandom);
               focus_b   = 3'($urandom);
            end
            case (pick_mode)
               0: ch = 3'($urandom);
               1: ch = focus_a;
               default: ch = $urandom_range(0, 1) ? focus_a : focus_b;
            endcase
            if (backlog_pos[ch] >= backlog_len[ch]) refill_link(ch);
            b = backlog[ch][backlog_pos[ch]];
            backlog_pos[ch]++;
            send_byte(ch, b);
            if (advance_link(ch, b, rep)) pending_reports.push_back(rep);
         end
      end

      settle_links();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d frame reports never arrived", pending_reports.size());
         fault_count++;
      end

      $display("%0d bytes over %0d links, %0d header settings", bytes_sent, LINKS, PHASES + 1);
      $display("frames closed: %0d good, %0d bad checksum, %0d overflow; %0d mismatches",
               good_seen, bad_sum_seen, overflow_seen, fault_count);
      if (fault_count == 0) begin
         $display("multi_channel_frame_receiver_test: clean");
      end else begin
         $display("multi_channel_frame_receiver_test: errors");
      end
      $finish;
   end

endmodule
